/* hdl/packet_descriptor_ring_manager_defines.svh */
// Assertion macros for the packet descriptor ring manager.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef PACKET_DESCRIPTOR_RING_MANAGER_DEFINES_SVH
`define PACKET_DESCRIPTOR_RING_MANAGER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define PDRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define PDRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PDRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PDRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/pdrm_pkg.sv */
// Package for the packet descriptor ring manager: sizes, codes and payload types.
// Used by the top level; depends on nothing.
`default_nettype none
package pdrm_pkg;

    localparam int MAX_SLOTS   = 64;
    localparam int SLOT_BITS   = $clog2(MAX_SLOTS);
    localparam int CNT_BITS    = $clog2(MAX_SLOTS + 1);
    localparam int OFFSET_BITS = 16;
    localparam int SIZE_BITS   = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOT_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RING_BYTES = 2'd1;

    // Command modes.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_TOO_SMALL = 2'd2,
        ST_BAD_SIZE  = 2'd3
    } t_status;

    typedef struct packed {
        logic                 mode;
        logic [SIZE_BITS-1:0] pkt_len;
    } t_pdrm_in;

    typedef struct packed {
        t_status                status;
        logic [5:0]             slot;
        logic [15:0]            byte_offset;
        logic [15:0]            byte_count;
    } t_pdrm_out;

endpackage
`default_nettype wire

/* hdl/packet_descriptor_ring_manager.sv */
// Top level of the packet descriptor ring manager: control, valid flags
// and descriptor memory. Depends on pdrm_pkg and the assertion macro header.
//
// Usage: a command (write a packet or read the next one) is taken at a
// rising edge with i_start high and o_busy low. Each command gives exactly
// one result on o_result, marked by o_result_valid for one cycle; the
// receiver cannot hold it off. Configuration (slot count, ring size) is
// written on i_cfg_we / i_cfg_index / i_cfg_data, one register per edge.
// Timing: writes, bad sizes and empty reads finish in the accept cycle and
// the result shows in the next cycle; a new command is taken at once.
// A read that finds a packet scans the valid flags in the accept cycle and
// reads the descriptor memory in the next one (S_RDATA), so o_busy is high
// for that one cycle and its result shows in the cycle after it.
// Sustained rate is one command per cycle for writes, bad sizes and empty
// reads; a read that finds a packet holds off the next command while o_busy
// is high, since the descriptor memory has a registered read port.
// Reset clears all valid flags, pointers, the held slot and the write
// offset at once; no clearing pass is needed. The descriptor memory is
// not reset.
`default_nettype none
`include "packet_descriptor_ring_manager_defines.svh"
module packet_descriptor_ring_manager (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    output logic                                      o_busy,
    input  wire pdrm_pkg::t_pdrm_in                   i_cmd,
    output logic                                      o_result_valid,
    output pdrm_pkg::t_pdrm_out                       o_result,
    input  wire logic                                 i_cfg_we,
    input  wire logic [pdrm_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [pdrm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import pdrm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_RDATA = 2'b10
    } t_state;

    // Control state.
    t_state                 r_state, n_state;
    logic [MAX_SLOTS-1:0]   r_slot_valid, n_slot_valid;
    logic [SLOT_BITS-1:0]   r_write_slot, n_write_slot;
    logic [SLOT_BITS-1:0]   r_read_slot, n_read_slot;
    logic [SLOT_BITS-1:0]   r_held_slot, n_held_slot;
    logic                   r_held_valid, n_held_valid;
    logic [OFFSET_BITS-1:0] r_write_offset, n_write_offset;
    logic [CNT_BITS-1:0]    r_slot_count;
    logic [15:0]            r_ring_bytes;
    logic                   r_res_valid, n_res_valid;
    t_pdrm_out              r_result, n_result;
    // Read phase payload.
    logic [SLOT_BITS-1:0]   r_rd_slot, n_rd_slot;
    logic [SIZE_BITS-1:0]   r_rd_cap, n_rd_cap;

    // Descriptor memory: {offset, size} per slot.
    logic [OFFSET_BITS+SIZE_BITS-1:0] r_desc_mem [MAX_SLOTS];
    logic [OFFSET_BITS+SIZE_BITS-1:0] r_desc_q;
    logic                             mem_we, mem_re;
    logic [SLOT_BITS-1:0]             mem_waddr, mem_raddr;
    logic [OFFSET_BITS+SIZE_BITS-1:0] mem_wdata;

    logic                   accept;
    logic [CNT_BITS-1:0]    slots_used;
    logic [MAX_SLOTS-1:0]   in_use_mask, from_start_mask;
    logic [MAX_SLOTS-1:0]   valid_freed, cand_all, cand_hi;
    logic [SLOT_BITS-1:0]   first_all, first_hi, found_slot;
    logic                   found;
    logic [SLOT_BITS-1:0]   wr_start, wr_slot, rd_start;
    logic [OFFSET_BITS:0]   end_sum, new_sum;
    logic [OFFSET_BITS-1:0] place_off;
    logic [SIZE_BITS-1:0]   req_size;
    logic [SIZE_BITS-1:0]   desc_size;
    logic [OFFSET_BITS-1:0] desc_off;

    // Next slot with wrap at the number of slots in use.
    function automatic logic [SLOT_BITS-1:0] next_slot(
        input logic [SLOT_BITS-1:0] s,
        input logic [CNT_BITS-1:0]  n
    );
        logic [CNT_BITS-1:0] sum;
        sum = {{(CNT_BITS-SLOT_BITS){1'b0}}, s} + CNT_BITS'(1);
        return (sum >= n) ? '0 : sum[SLOT_BITS-1:0];
    endfunction

    // Lowest set bit of a flag vector.
    function automatic logic [SLOT_BITS-1:0] lowest_set(input logic [MAX_SLOTS-1:0] v);
        logic [SLOT_BITS-1:0] idx;
        idx = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = SLOT_BITS'(i);
            end
        end
        return idx;
    endfunction

    assign accept   = i_start && (r_state == S_IDLE);
    assign req_size = i_cmd.pkt_len;

    // Slot count clamped to 1..MAX_SLOTS.
    always_comb begin
        if (r_slot_count == '0) begin
            slots_used = CNT_BITS'(1);
        end else if (r_slot_count > CNT_BITS'(MAX_SLOTS)) begin
            slots_used = CNT_BITS'(MAX_SLOTS);
        end else begin
            slots_used = r_slot_count;
        end
    end

    // Start points, with pointers past the slot count acting as slot 0.
    assign wr_start = ({1'b0, r_write_slot} >= slots_used) ? '0 : r_write_slot;
    assign rd_start = ({1'b0, r_read_slot} >= slots_used) ? '0 : r_read_slot;
    assign wr_slot  = (r_held_valid && (wr_start == r_held_slot)) ?
                      next_slot(wr_start, slots_used) : wr_start;

    // Find the next valid slot at or after the read pointer, with wrap.
    always_comb begin
        valid_freed = r_slot_valid;
        if (r_held_valid) begin
            valid_freed[r_held_slot] = 1'b0;
        end
        for (int i = 0; i < MAX_SLOTS; i++) begin
            in_use_mask[i]     = (CNT_BITS'(i) < slots_used);
            from_start_mask[i] = (SLOT_BITS'(i) >= rd_start);
        end
        cand_all   = valid_freed & in_use_mask;
        cand_hi    = cand_all & from_start_mask;
        first_all  = lowest_set(cand_all);
        first_hi   = lowest_set(cand_hi);
        found      = (cand_all != '0);
        found_slot = (cand_hi != '0) ? first_hi : first_all;
    end

    // Packet placement in the byte ring.
    always_comb begin
        end_sum   = {1'b0, r_write_offset} + {1'b0, req_size};
        place_off = (end_sum > {1'b0, r_ring_bytes}) ? '0 : r_write_offset;
        new_sum   = {1'b0, place_off} + {1'b0, req_size};
        if (new_sum >= {1'b0, r_ring_bytes}) begin
            new_sum = new_sum - {1'b0, r_ring_bytes};
        end
    end

    assign desc_off  = r_desc_q[OFFSET_BITS+SIZE_BITS-1:SIZE_BITS];
    assign desc_size = r_desc_q[SIZE_BITS-1:0];

    // Command sequencing and state update.
    always_comb begin
        n_state        = r_state;
        n_slot_valid   = r_slot_valid;
        n_write_slot   = r_write_slot;
        n_read_slot    = r_read_slot;
        n_held_slot    = r_held_slot;
        n_held_valid   = r_held_valid;
        n_write_offset = r_write_offset;
        n_res_valid    = 1'b0;
        n_result       = r_result;
        n_rd_slot      = r_rd_slot;
        n_rd_cap       = r_rd_cap;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = wr_slot;
        mem_raddr      = found_slot;
        mem_wdata      = {place_off, req_size};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.mode == MODE_WRITE) begin
                        if ((req_size == '0) || (req_size > r_ring_bytes)) begin
                            n_result    = '{ST_BAD_SIZE, '0, '0, '0};
                            n_res_valid = 1'b1;
                        end else begin
                            mem_we                = 1'b1;
                            n_slot_valid[wr_slot] = 1'b1;
                            n_write_slot          = next_slot(wr_slot, slots_used);
                            n_write_offset        = new_sum[OFFSET_BITS-1:0];
                            n_result    = '{ST_OK, wr_slot, place_off, req_size};
                            n_res_valid = 1'b1;
                        end
                    end else if (req_size == '0) begin
                        n_result    = '{ST_BAD_SIZE, '0, '0, '0};
                        n_res_valid = 1'b1;
                    end else begin
                        // Free the held slot, then take the next valid one.
                        n_slot_valid = valid_freed;
                        n_held_valid = 1'b0;
                        if (!found) begin
                            n_result    = '{ST_EMPTY, '0, '0, '0};
                            n_res_valid = 1'b1;
                        end else begin
                            mem_re       = 1'b1;
                            n_held_slot  = found_slot;
                            n_held_valid = 1'b1;
                            n_read_slot  = next_slot(found_slot, slots_used);
                            n_rd_slot    = found_slot;
                            n_rd_cap     = req_size;
                            n_state      = S_RDATA;
                        end
                    end
                end
            end
            S_RDATA: begin
                // Descriptor data is back from memory.
                n_result.status      = (r_rd_cap >= desc_size) ? ST_OK : ST_TOO_SMALL;
                n_result.slot        = r_rd_slot;
                n_result.byte_offset = desc_off;
                n_result.byte_count  = desc_size;
                n_res_valid          = 1'b1;
                n_state              = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_slot_valid   <= '0;
            r_write_slot   <= '0;
            r_read_slot    <= '0;
            r_held_slot    <= '0;
            r_held_valid   <= 1'b0;
            r_write_offset <= '0;
            r_res_valid    <= 1'b0;
            r_slot_count   <= CNT_BITS'(MAX_SLOTS);
            r_ring_bytes   <= 16'hFFFF;
        end else begin
            r_state        <= n_state;
            r_slot_valid   <= n_slot_valid;
            r_write_slot   <= n_write_slot;
            r_read_slot    <= n_read_slot;
            r_held_slot    <= n_held_slot;
            r_held_valid   <= n_held_valid;
            r_write_offset <= n_write_offset;
            r_res_valid    <= n_res_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SLOT_COUNT: r_slot_count <= i_cfg_data[CNT_BITS-1:0];
                    CFG_RING_BYTES: r_ring_bytes <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_result  <= n_result;
        r_rd_slot <= n_rd_slot;
        r_rd_cap  <= n_rd_cap;
    end

    // Descriptor memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_desc_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_desc_q <= r_desc_mem[mem_raddr];
        end
    end

    assign o_busy         = (r_state == S_RDATA);
    assign o_result_valid = r_res_valid;
    assign o_result       = r_result;

    // The memory read phase always ends with a result in the next cycle.
    `PDRM_ASSERT_NEXT(a_rdata_gives_result, i_clk, i_rst_n, r_state == S_RDATA, o_result_valid && !o_busy)
    // A slot held by the reader stays valid until the next nonzero-size read frees it.
    `PDRM_ASSERT_NOW(a_held_is_valid, i_clk, i_rst_n, r_held_valid, r_slot_valid[r_held_slot])
    // Empty and bad-size results carry zero fields.
    `PDRM_ASSERT_NOW(a_zero_fields, i_clk, i_rst_n, o_result_valid && ((o_result.status == ST_EMPTY) || (o_result.status == ST_BAD_SIZE)), (o_result.slot == '0) && (o_result.byte_offset == '0) && (o_result.byte_count == '0))
    // No command is taken during the read phase, and S_RDATA always returns to S_IDLE.
    `PDRM_ASSERT_NEXT(a_busy_one_cycle, i_clk, i_rst_n, o_busy, !o_busy)

endmodule
`default_nettype wire

/* bench/packet_descriptor_ring_manager_test.sv */
// Self-checking testbench for the packet descriptor ring manager.
// Drives write and read commands with random gaps and checks every result transfer.
// Depends on pdrm_pkg and the packet_descriptor_ring_manager top level.
`timescale 1ns / 100ps
module packet_descriptor_ring_manager_test;
    import pdrm_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    t_pdrm_in                 i_cmd;
    logic                     o_result_valid;
    t_pdrm_out                o_result;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    packet_descriptor_ring_manager dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the descriptor ring, kept in step with accepted commands.
    bit           ring_valid [MAX_SLOTS];
    logic [15:0]  ring_offset [MAX_SLOTS];
    logic [15:0]  ring_size [MAX_SLOTS];
    int unsigned  next_write_slot = 0;
    int unsigned  next_read_slot = 0;
    int unsigned  reader_slot = 0;
    bit           reader_holds = 1'b0;
    int unsigned  packets_stored = 0;
    int unsigned  fill_offset = 0;
    int unsigned  cfg_slots = 64;
    int unsigned  cfg_ring = 65535;

    t_pdrm_out    pending_results [$];
    int           errors = 0;

    function automatic int unsigned wrap_next(input int unsigned s, input int unsigned n);
        return (s + 1 >= n) ? 0 : s + 1;
    endfunction

    // Work out the result of one accepted command and update the shadow ring.
    function automatic t_pdrm_out predict_ring(input t_pdrm_in c);
        t_pdrm_out   r;
        int unsigned n;
        int unsigned cur;
        int unsigned off;
        int unsigned k;
        bit          found;
        r = '0;
        r.status = ST_OK;
        n = (cfg_slots == 0) ? 1 : (cfg_slots > MAX_SLOTS) ? MAX_SLOTS : cfg_slots;
        if (c.mode == MODE_WRITE) begin
            if (c.pkt_len == 0 || c.pkt_len > cfg_ring) begin
                r.status = ST_BAD_SIZE;
            end else begin
                cur = (next_write_slot >= n) ? 0 : next_write_slot;
                // Step past the slot the reader holds.
                if (reader_holds && cur == reader_slot) cur = wrap_next(cur, n);
                if (!ring_valid[cur]) begin
                    ring_valid[cur] = 1'b1;
                    packets_stored++;
                end
                off = fill_offset;
                if (off + c.pkt_len > cfg_ring) off = 0;
                ring_offset[cur] = off[15:0];
                ring_size[cur] = c.pkt_len;
                next_write_slot = wrap_next(cur, n);
                fill_offset = off + c.pkt_len;
                if (fill_offset >= cfg_ring) fill_offset -= cfg_ring;
                r.slot = cur[5:0];
                r.byte_offset = off[15:0];
                r.byte_count = c.pkt_len;
            end
        end else if (c.pkt_len == 0) begin
            r.status = ST_BAD_SIZE;
        end else begin
            // Release the slot held since the previous read.
            if (reader_holds) begin
                if (ring_valid[reader_slot]) begin
                    ring_valid[reader_slot] = 1'b0;
                    if (packets_stored > 0) packets_stored--;
                end
                reader_holds = 1'b0;
            end
            found = 1'b0;
            cur = (next_read_slot >= n) ? 0 : next_read_slot;
            if (packets_stored != 0) begin
                for (k = 0; k < n && !found; k++) begin
                    if (ring_valid[cur]) found = 1'b1;
                    else cur = wrap_next(cur, n);
                end
            end
            if (!found) begin
                r.status = ST_EMPTY;
            end else begin
                next_read_slot = wrap_next(cur, n);
                reader_slot = cur;
                reader_holds = 1'b1;
                r.status = (c.pkt_len >= ring_size[cur]) ? ST_OK : ST_TOO_SMALL;
                r.slot = cur[5:0];
                r.byte_offset = ring_offset[cur];
                r.byte_count = ring_size[cur];
            end
        end
        return r;
    endfunction

    // Random packet size: mostly sizes that fit the ring, some bad or full-range.
    function automatic logic [15:0] pick_size(input logic mode);
        int unsigned roll;
        int unsigned lim;
        int unsigned v;
        roll = $urandom_range(0, 19);
        lim = (cfg_ring > 3) ? cfg_ring / 4 : 1;
        if (roll == 0) begin
            v = 0;
        end else if (roll < 4) begin
            v = $urandom_range(0, 65535);
        end else if (mode == MODE_WRITE) begin
            if (roll == 4 && cfg_ring < 65535) v = $urandom_range(cfg_ring + 1, 65535);
            else if (roll < 12) v = $urandom_range(1, lim);
            else v = $urandom_range(1, cfg_ring);
        end else begin
            if (roll < 12) v = $urandom_range(1, 2 * lim + 1);
            else v = $urandom_range(1, 65535);
        end
        return v[15:0];
    endfunction

    // Check each result transfer against the oldest pending prediction.
    always @(posedge i_clk) begin
        t_pdrm_out want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer: status %0d slot %0d offset %0d count %0d",
                         $time, o_result.status, o_result.slot, o_result.byte_offset,
                         o_result.byte_count);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status || o_result.slot !== want.slot ||
                    o_result.byte_offset !== want.byte_offset ||
                    o_result.byte_count !== want.byte_count) begin
                    $display("%0t: result mismatch: expected status %0d slot %0d offset %0d count %0d",
                             $time, want.status, want.slot, want.byte_offset, want.byte_count);
                    $display("%0t:                  actual   status %0d slot %0d offset %0d count %0d",
                             $time, o_result.status, o_result.slot, o_result.byte_offset,
                             o_result.byte_count);
                    errors++;
                end
            end
        end
    end

    // Present one command and hold it until the block takes it.
    task automatic send_cmd(input logic mode, input logic [15:0] size);
        t_pdrm_in c;
        c.mode = mode;
        c.pkt_len = size;
        @(negedge i_clk);
        i_start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        pending_results.push_back(predict_ring(c));
    endtask

    // Drop start for a gap of random length, with junk on the command bus.
    task automatic idle_gap();
        int       n;
        t_pdrm_in junk;
        n = $urandom_range(1, 8);
        junk.mode = 1'($urandom_range(0, 1));
        junk.pkt_len = 16'($urandom_range(0, 65535));
        @(negedge i_clk);
        i_start <= 1'b0;
        i_cmd <= junk;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Stop sending and wait until every predicted result has been seen.
    task automatic wait_idle();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_SLOT_COUNT) cfg_slots = val[6:0];
        else if (idx == CFG_RING_BYTES) cfg_ring = val;
    endtask

    // Reconfigure both registers once the block has drained.
    task automatic set_ring(input logic [6:0] slots, input logic [15:0] ring_len);
        int unsigned hi;
        hi = $urandom_range(0, 511);
        wait_idle();
        write_cfg(CFG_SLOT_COUNT, {hi[8:0], slots});
        write_cfg(CFG_RING_BYTES, ring_len);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random mix of writes and reads under the current configuration.
    task automatic run_traffic(input int count, input int write_pct, input bit gaps);
        int   k;
        logic mode;
        for (k = 0; k < count; k++) begin
            mode = ($urandom_range(0, 99) < write_pct) ? MODE_WRITE : MODE_READ;
            send_cmd(mode, pick_size(mode));
            if (gaps && $urandom_range(0, 3) == 0) idle_gap();
            else if (gaps && $urandom_range(0, 199) == 0) wait_idle();
        end
    endtask

    // Reads on an empty queue, zero sizes, full-width sizes and a short reader buffer.
    task automatic test_bad_sizes_and_empty();
        send_cmd(MODE_READ, 16'd1);
        send_cmd(MODE_WRITE, 16'd0);
        send_cmd(MODE_READ, 16'd0);
        send_cmd(MODE_WRITE, 16'hFFFF);
        send_cmd(MODE_WRITE, 16'd2);
        send_cmd(MODE_READ, 16'hFFFF);
        // A zero-size read leaves the held slot alone.
        send_cmd(MODE_READ, 16'd0);
        send_cmd(MODE_READ, 16'd1);
        send_cmd(MODE_READ, 16'h8000);
    endtask

    // Packets that would pass the ring end restart at offset zero.
    task automatic test_ring_wrap();
        set_ring(7'd8, 16'd100);
        send_cmd(MODE_WRITE, 16'd60);
        send_cmd(MODE_WRITE, 16'd60);
        send_cmd(MODE_WRITE, 16'd101);
        send_cmd(MODE_WRITE, 16'd100);
    endtask

    // Writes step around the slot the reader currently holds.
    task automatic test_held_slot_skip();
        set_ring(7'd3, 16'd1000);
        send_cmd(MODE_WRITE, 16'd10);
        send_cmd(MODE_READ, 16'd10);
        send_cmd(MODE_WRITE, 16'd11);
        send_cmd(MODE_WRITE, 16'd12);
        send_cmd(MODE_WRITE, 16'd13);
    endtask

    // A slot count of zero acts as one slot, so a write rewrites the held slot.
    task automatic test_single_slot();
        set_ring(7'd0, 16'd1000);
        send_cmd(MODE_WRITE, 16'd5);
        send_cmd(MODE_READ, 16'd5);
        send_cmd(MODE_WRITE, 16'd7);
        send_cmd(MODE_READ, 16'd7);
    endtask

    // Shrinking and regrowing the slot count strands and recovers packets.
    task automatic test_slot_count_changes();
        set_ring(7'd64, 16'hFFFF);
        run_traffic(120, 75, 1'b1);
        set_ring(7'd2, 16'hFFFF);
        run_traffic(100, 40, 1'b1);
        set_ring(7'd127, 16'd1000);
        run_traffic(100, 50, 1'b1);
        set_ring(7'd1, 16'd1);
        run_traffic(80, 50, 1'b1);
        set_ring(7'd16, 16'd300);
        run_traffic(100, 60, 1'b1);
        set_ring(7'd64, 16'hFFFF);
        run_traffic(100, 30, 1'b1);
        set_ring(7'd0, 16'd50);
        run_traffic(60, 50, 1'b1);
    endtask

    // Random configurations; the last phases run without gaps.
    task automatic test_random_traffic();
        int          p;
        int unsigned roll;
        int unsigned slots;
        int unsigned ring_len;
        for (p = 0; p < 8; p++) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) slots = 0;
            else if (roll == 1) slots = $urandom_range(65, 127);
            else if (roll == 2) slots = 64;
            else slots = $urandom_range(1, 16);
            ring_len = $urandom_range(0, 1) ? $urandom_range(1, 400) : $urandom_range(1, 65535);
            set_ring(slots[6:0], ring_len[15:0]);
            run_traffic(100, $urandom_range(30, 70), p < 6);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_SLOT_COUNT;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_bad_sizes_and_empty();
        test_ring_wrap();
        test_held_slot_skip();
        test_single_slot();
        test_slot_count_changes();
        test_random_traffic();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
